// ===== rtl/core/cbu_pkg.sv =====
// Shared types and constants of the coefficient bit unpacker.
package cbu_pkg;

   localparam int BYTE_W       = 8;
   localparam int COEFF_W      = 12;
   localparam int CFG_W        = 4;
   localparam int BUF_W        = 19;
   localparam int CNT_W        = 5;
   localparam int QUEUE_DEPTH  = 2;
   localparam int DEF_POLY_LEN = 256;
   localparam int DEF_MODULUS  = 3329;

   localparam logic [CFG_W-1:0] FULL_WIDTH = CFG_W'(12);
   localparam logic [CFG_W-1:0] MIN_WIDTH  = CFG_W'(1);

   // Head entry of the byte queue as the extraction stage sees it.
   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] data;
   } byte_slot_type;

endpackage

// ===== rtl/core/coefficient_bit_unpacker_top.sv =====
// Top level of the coefficient bit unpacker: byte queue followed by the extraction stage.
//
// The unpacker turns a byte stream into coefficients of 1 to 12 bits, least significant
// bit first, reducing each 12-bit coefficient once by MODULUS and wrapping the coefficient
// index after POLY_LEN coefficients, at which point any bits left over are dropped. At
// widths of 8 to 12 bits it takes one byte every cycle while the result register is free;
// below 8 bits a byte yields up to 8/width coefficients, rounded up, and the extraction
// stage produces one per cycle while the result register is free, taking another byte
// only once the bits held cannot form another coefficient. A two-entry byte queue lets
// input transfers continue while a result waits on rsp_ready. A write on the csr channel
// sets the width (0 acts as 1, 13 to 15 act as 12) and starts a new polynomial; write it
// only while the block is idle. There is no clearing pass after reset.
module coefficient_bit_unpacker_top #(
   parameter int POLY_LEN = cbu_pkg::DEF_POLY_LEN,
   parameter int MODULUS  = cbu_pkg::DEF_MODULUS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [cbu_pkg::CFG_W-1:0]   csr_coeff_bits,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [cbu_pkg::BYTE_W-1:0]  req_data_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [cbu_pkg::COEFF_W-1:0] rsp_coefficient,
   output logic                        rsp_last_from_byte,
   output logic                        rsp_last_of_poly
);
   import cbu_pkg::*;

   byte_slot_type head;
   logic          pop;

   assign csr_ready = 1'b1;

   cbu_byte_queue u_queue (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .head          (head),
      .pop           (pop)
   );

   cbu_extract #(
      .POLY_LEN (POLY_LEN),
      .MODULUS  (MODULUS)
   ) u_extract (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_coeff_bits     (csr_coeff_bits),
      .head               (head),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_coefficient    (rsp_coefficient),
      .rsp_last_from_byte (rsp_last_from_byte),
      .rsp_last_of_poly   (rsp_last_of_poly)
   );

endmodule

// ===== rtl/core/cbu_byte_queue.sv =====
// Front part: accepts packed bytes and holds them in a short queue.
module cbu_byte_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [cbu_pkg::BYTE_W-1:0]  req_data_byte,
   output cbu_pkg::byte_slot_type      head,
   input  logic                        pop
);
   import cbu_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

   logic [BYTE_W-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [OCC_W-1:0]  occ_ff, occ_in;
   logic              push;
   logic              do_pop;

   assign req_ready = (occ_ff != OCC_W'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign do_pop    = pop && (occ_ff != '0);

   assign head.valid = (occ_ff != '0);
   assign head.data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      occ_in    = occ_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !do_pop) begin
         occ_in = occ_ff + OCC_W'(1);
      end else if (do_pop && !push) begin
         occ_in = occ_ff - OCC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         occ_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         occ_ff    <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= req_data_byte;
      end
   end

   a_occ_bounded: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(QUEUE_DEPTH))
      else $error("byte queue occupancy beyond its depth");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      (occ_ff == '0 && !push) |=> (occ_ff == '0))
      else $error("byte queue gained an entry without a transfer");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (occ_ff == '0 || occ_ff == OCC_W'(QUEUE_DEPTH)) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("byte queue pointers disagree with occupancy");

endmodule

// ===== rtl/core/cbu_extract.sv =====
// Back part: bit buffer, coefficient extraction, reduction and result register.
module cbu_extract #(
   parameter int POLY_LEN = cbu_pkg::DEF_POLY_LEN,
   parameter int MODULUS  = cbu_pkg::DEF_MODULUS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_valid,
   input  logic [cbu_pkg::CFG_W-1:0]   csr_coeff_bits,
   input  cbu_pkg::byte_slot_type      head,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [cbu_pkg::COEFF_W-1:0] rsp_coefficient,
   output logic                        rsp_last_from_byte,
   output logic                        rsp_last_of_poly
);
   import cbu_pkg::*;

   localparam int IDX_W = $clog2(POLY_LEN);
   localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(POLY_LEN - 1);
   localparam logic [COEFF_W-1:0] MOD_VAL  = COEFF_W'(MODULUS);

   logic [CFG_W-1:0]   width_ff, width_in;
   logic [BUF_W-1:0]   buf_ff, buf_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               out_valid_ff, out_valid_in;
   logic [COEFF_W-1:0] out_coeff_ff;
   logic               out_last_byte_ff;
   logic               out_last_poly_ff;

   logic               need_byte;
   logic               load;
   logic [BUF_W-1:0]   merged;
   logic [CNT_W-1:0]   merged_count;
   logic [CNT_W-1:0]   width_ext;
   logic [CNT_W-1:0]   rest_count;
   logic [COEFF_W-1:0] mask;
   logic [COEFF_W-1:0] raw;
   logic [COEFF_W-1:0] reduced;
   logic               out_free;
   logic               emit;
   logic               poly_end;
   logic               last_byte;
   logic [CFG_W-1:0]   new_width;

   assign width_ext    = {{(CNT_W-CFG_W){1'b0}}, width_ff};
   assign need_byte    = (count_ff < width_ext);
   assign load         = need_byte && head.valid;
   assign pop          = load;
   assign merged       = load ? (buf_ff | ({{(BUF_W-BYTE_W){1'b0}}, head.data} << count_ff))
                              : buf_ff;
   assign merged_count = load ? (count_ff + CNT_W'(BYTE_W)) : count_ff;
   assign rest_count   = merged_count - width_ext;

   assign out_free = !out_valid_ff || rsp_ready;
   assign emit     = (merged_count >= width_ext) && out_free;
   assign poly_end = (idx_ff == LAST_IDX);
   // Byte used up at poly end or once the bits left cannot form another coeff.
   assign last_byte = poly_end || (rest_count < width_ext);

   assign mask    = ~({COEFF_W{1'b1}} << width_ff);
   assign raw     = merged[COEFF_W-1:0] & mask;
   assign reduced = ((width_ff == FULL_WIDTH) && (raw >= MOD_VAL)) ? (raw - MOD_VAL) : raw;

   always_comb begin
      if (csr_coeff_bits == '0) begin
         new_width = MIN_WIDTH;
      end else if (csr_coeff_bits > FULL_WIDTH) begin
         new_width = FULL_WIDTH;
      end else begin
         new_width = csr_coeff_bits;
      end
   end

   always_comb begin
      width_in     = width_ff;
      buf_in       = merged;
      count_in     = merged_count;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      if (emit) begin
         out_valid_in = 1'b1;
         if (poly_end) begin
            buf_in   = '0;
            count_in = '0;
            idx_in   = '0;
         end else begin
            buf_in   = merged >> width_ff;
            count_in = rest_count;
            idx_in   = idx_ff + IDX_W'(1);
         end
      end
      // A register write starts a new polynomial.
      if (csr_valid) begin
         width_in = new_width;
         buf_in   = '0;
         count_in = '0;
         idx_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= FULL_WIDTH;
         buf_ff       <= '0;
         count_ff     <= '0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         buf_ff       <= buf_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_coeff_ff     <= reduced;
         out_last_byte_ff <= last_byte;
         out_last_poly_ff <= poly_end;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_coefficient    = out_coeff_ff;
   assign rsp_last_from_byte = out_last_byte_ff;
   assign rsp_last_of_poly   = out_last_poly_ff;

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff < width_ext + CNT_W'(BYTE_W))
      else $error("bit count exceeds what one byte can leave");

   a_poly_end_clears: assert property (@(posedge clock) disable iff (reset)
      (emit && poly_end) |=> (count_ff == '0 && idx_ff == '0 && buf_ff == '0))
      else $error("bit buffer not emptied at the end of a polynomial");

   a_more_from_byte: assert property (@(posedge clock) disable iff (reset)
      (emit && !last_byte && !csr_valid) |=> (count_ff >= width_ext))
      else $error("coefficient flagged as not last but no bits remain");

   a_last_poly_marks_byte: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_last_poly_ff) |-> out_last_byte_ff)
      else $error("end of polynomial without end of byte");

endmodule

// ===== tb/coefficient_bit_unpacker_top_tb.sv =====
// Self-checking testbench for the coefficient bit unpacker top level.
module coefficient_bit_unpacker_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cbu_pkg::*;

   localparam int POLY_LEN      = DEF_POLY_LEN;
   localparam int MODULUS       = DEF_MODULUS;
   localparam int MAX_PER_BYTE  = 8;
   localparam int SETTLE_CYCLES = 10;
   localparam int HOLD_CYCLES   = 100;
   localparam int QUIET_LIMIT   = 2000;
   localparam int REPORT_LIMIT  = 10;
   localparam int NUM_DIRECTED  = 24;
   localparam int NUM_SEGMENTS  = 8;

   typedef struct packed {
      logic [COEFF_W-1:0] coefficient;
      logic               last_from_byte;
      logic               last_of_poly;
   } unpacked_coeff_type;

   typedef enum logic {ROW_BYTE, ROW_CSR} row_kind_type;

   // A typed row carries the single coefficient its byte must produce.
   typedef struct packed {
      row_kind_type       kind;
      logic [BYTE_W-1:0]  value;
      logic               typed;
      logic [COEFF_W-1:0] coefficient;
      logic               last_from_byte;
      logic               last_of_poly;
   } directed_row_type;

   typedef struct packed {
      logic [CFG_W-1:0] width;
      logic [7:0]       bytes;
      logic [6:0]       send_idle;
      logic [6:0]       recv_stall;
   } segment_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CFG_W-1:0]    csr_coeff_bits = '0;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [BYTE_W-1:0]   req_data_byte = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [COEFF_W-1:0]  rsp_coefficient;
   logic                rsp_last_from_byte;
   logic                rsp_last_of_poly;

   coefficient_bit_unpacker_top dut (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_coeff_bits     (csr_coeff_bits),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_coefficient    (rsp_coefficient),
      .rsp_last_from_byte (rsp_last_from_byte),
      .rsp_last_of_poly   (rsp_last_of_poly)
   );

   // Predictor state, mirroring the block after reset.
   logic [CFG_W-1:0] width_reg  = FULL_WIDTH;
   logic [BUF_W-1:0] held_bits  = '0;
   logic [CNT_W-1:0] held_count = '0;
   int               coeff_pos  = 0;

   unpacked_coeff_type expected_coeffs[$];
   unpacked_coeff_type oldest_coeff;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   bit hold_off_pending = 1'b0;
   int hold_left     = 0;
   int quiet_cycles  = 0;
   int failures      = 0;
   int bytes_sent    = 0;
   int coeffs_seen   = 0;
   int polys_seen    = 0;
   int width_writes  = 0;

   directed_row_type directed_rows [NUM_DIRECTED] = '{
      '{ROW_BYTE, 8'hFF, 1'b0, 12'd0,    1'b0, 1'b0},
      '{ROW_BYTE, 8'hFF, 1'b1, 12'd766,  1'b1, 1'b0},
      '{ROW_BYTE, 8'h00, 1'b0, 12'd0,    1'b0, 1'b0},
      '{ROW_CSR,  8'd1,  1'b0, 12'd0,    1'b0, 1'b0},
      '{ROW_BYTE, 8'hA5, 1'b0, 12'd0,    1'b0, 1'b0},
      '{ROW_CSR,  8'd0,  1'b0, 12'd0,    1'b0, 1'b0},
      '{ROW_BYTE, 8'h00, 1'b0, 12'd0,    1'b0, 1'b0},
      '{ROW_BYTE, 8'hFF, 1'b0, 12'd0,    1'b0, 1'b0},
      '{ROW_CSR,  8'd8,  1'b0, 12'd0,    1'b0, 1'b0},
      '{ROW_BYTE, 8'h00, 1'b1, 12'd0,    1'b1, 1'b0},
      '{ROW_BYTE, 8'hFF, 1'b1, 12'd255,  1'b1, 1'b0},
      '{ROW_CSR,  8'd13, 1'b0, 12'd0,    1'b0, 1'b0},
      '{ROW_BYTE, 8'h01, 1'b0, 12'd0,    1'b0, 1'b0},
      '{ROW_BYTE, 8'h0D, 1'b1, 12'd0,    1'b1, 1'b0},
      '{ROW_CSR,  8'd15, 1'b0, 12'd0,    1'b0, 1'b0},
      '{ROW_BYTE, 8'h00, 1'b0, 12'd0,    1'b0, 1'b0},
      '{ROW_BYTE, 8'h0D, 1'b1, 12'd3328, 1'b1, 1'b0},
      '{ROW_CSR,  8'd7,  1'b0, 12'd0,    1'b0, 1'b0},
      '{ROW_BYTE, 8'h7F, 1'b0, 12'd0,    1'b0, 1'b0},
      '{ROW_BYTE, 8'h80, 1'b0, 12'd0,    1'b0, 1'b0},
      '{ROW_CSR,  8'd2,  1'b0, 12'd0,    1'b0, 1'b0},
      '{ROW_BYTE, 8'hE4, 1'b0, 12'd0,    1'b0, 1'b0},
      '{ROW_CSR,  8'd12, 1'b0, 12'd0,    1'b0, 1'b0},
      '{ROW_BYTE, 8'hFF, 1'b0, 12'd0,    1'b0, 1'b0}
   };

   // Widths 1, 0 and 2 run long enough to close whole polynomials.
   segment_type segments [NUM_SEGMENTS] = '{
      '{4'd1,  8'd40, 7'd0,  7'd0},
      '{4'd12, 8'd30, 7'd0,  7'd0},
      '{4'd2,  8'd64, 7'd67, 7'd0},
      '{4'd7,  8'd20, 7'd67, 7'd0},
      '{4'd0,  8'd32, 7'd0,  7'd67},
      '{4'd15, 8'd24, 7'd0,  7'd67},
      '{4'd4,  8'd30, 7'd33, 7'd33},
      '{4'd3,  8'd10, 7'd33, 7'd33}
   };

   initial begin
      forever #5 clock = ~clock;
   end

   // Appends one byte to the held bits and queues every coefficient it completes.
   function automatic int unpack_byte(input logic [BYTE_W-1:0] data);
      int                 w;
      int                 avail;
      int                 produced;
      logic [31:0]        pool;
      logic [31:0]        value;
      bit                 poly_done;
      unpacked_coeff_type coeff;
      if (width_reg == 0)
         w = MIN_WIDTH;
      else if (width_reg > FULL_WIDTH)
         w = FULL_WIDTH;
      else
         w = width_reg;
      pool = (32'(held_bits) | (32'(data) << held_count)) & 32'h7FFFF;
      avail = held_count + BYTE_W;
      produced = 0;
      poly_done = 1'b0;
      while (avail >= w && produced < MAX_PER_BYTE && !poly_done) begin
         value = pool & ((32'd1 << w) - 1);
         pool = pool >> w;
         avail = avail - w;
         if (w == FULL_WIDTH && value >= MODULUS)
            value = value - MODULUS;
         coeff_pos = coeff_pos + 1;
         poly_done = (coeff_pos >= POLY_LEN);
         coeff.coefficient = value[COEFF_W-1:0];
         coeff.last_from_byte = 1'b0;
         coeff.last_of_poly = poly_done;
         expected_coeffs.push_back(coeff);
         produced = produced + 1;
      end
      if (poly_done) begin
         pool = '0;
         avail = 0;
         coeff_pos = 0;
      end
      if (produced > 0) begin
         coeff = expected_coeffs.pop_back();
         coeff.last_from_byte = 1'b1;
         expected_coeffs.push_back(coeff);
      end
      held_bits = pool[BUF_W-1:0];
      held_count = avail[CNT_W-1:0];
      return produced;
   endfunction

   task automatic send_byte(input logic [BYTE_W-1:0] data, output int produced);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data_byte <= data;
      do @(posedge clock); while (!req_ready);
      produced = unpack_byte(data);
      bytes_sent++;
   endtask

   // Waits until every queued coefficient has come out, then lets any byte that
   // produces nothing pass through the byte queue.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_coeffs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_width(input logic [CFG_W-1:0] width);
      drain_results();
      csr_valid <= 1'b1;
      csr_coeff_bits <= width;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      width_reg = width;
      held_bits = '0;
      held_count = '0;
      coeff_pos = 0;
      width_writes++;
   endtask

   task automatic note_failure(input string what, input unpacked_coeff_type want,
                               input unpacked_coeff_type got);
      failures++;
      if (failures <= REPORT_LIMIT)
         $display("%s: expected coeff=%0d last_byte=%0b last_poly=%0b, %s",
                  what, want.coefficient, want.last_from_byte, want.last_of_poly,
                  $sformatf("got coeff=%0d last_byte=%0b last_poly=%0b",
                            got.coefficient, got.last_from_byte, got.last_of_poly));
   endtask

   always @(posedge clock) begin
      if (hold_off_pending) begin
         hold_left = HOLD_CYCLES;
         hold_off_pending = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         coeffs_seen++;
         if (rsp_last_of_poly)
            polys_seen++;
         if (expected_coeffs.size() == 0) begin
            note_failure("Unexpected coefficient", '0,
                         {rsp_coefficient, rsp_last_from_byte, rsp_last_of_poly});
         end else begin
            oldest_coeff = expected_coeffs.pop_front();
            if (rsp_coefficient !== oldest_coeff.coefficient ||
                rsp_last_from_byte !== oldest_coeff.last_from_byte ||
                rsp_last_of_poly !== oldest_coeff.last_of_poly)
               note_failure("Coefficient mismatch", oldest_coeff,
                            {rsp_coefficient, rsp_last_from_byte, rsp_last_of_poly});
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Timeout: no transfer for %0d cycles, %0d coefficients outstanding",
                  quiet_cycles, expected_coeffs.size());
         $display("** coefficient_bit_unpacker_top: FAILED **");
         $finish;
      end
   end

   initial begin
      directed_row_type row;
      segment_type      seg;
      int               produced;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_DIRECTED; i++) begin
         row = directed_rows[i];
         if (row.kind == ROW_CSR) begin
            write_width(row.value[CFG_W-1:0]);
         end else begin
            send_byte(row.value, produced);
            if (row.typed) begin
               repeat (produced) void'(expected_coeffs.pop_back());
               expected_coeffs.push_back({row.coefficient, row.last_from_byte,
                                          row.last_of_poly});
            end
         end
      end

      for (int s = 0; s < NUM_SEGMENTS; s++) begin
         seg = segments[s];
         // The closing segment picks any register value, out-of-range ones included.
         if (s == NUM_SEGMENTS - 1)
            seg.width = CFG_W'($urandom_range(0, 15));
         write_width(seg.width);
         send_idle_pct = seg.send_idle;
         stall_pct = seg.recv_stall;
         for (int b = 0; b < seg.bytes; b++) begin
            // At width 1 a long receiver hold-off fills the block and stalls its input.
            if (s == 0 && b == 8)
               hold_off_pending = 1'b1;
            if (s == 2 && b == 30)
               drain_results();
            send_byte(BYTE_W'($urandom_range(0, 255)), produced);
         end
      end

      drain_results();
      $display("Sent %0d bytes over %0d width writes;", bytes_sent, width_writes);
      $display("checked %0d coefficients, %0d full polynomials.", coeffs_seen, polys_seen);
      if (failures == 0 && expected_coeffs.size() == 0) begin
         $display("** coefficient_bit_unpacker_top: PASSED **");
      end else begin
         $display("%0d failures", failures + expected_coeffs.size());
         $display("** coefficient_bit_unpacker_top: FAILED **");
      end
      $finish;
   end

endmodule
